>>> src/wireless_buzzer_lockout_node_macros.svh
// Assertion macros shared by the RTL. They expect clk and arst_n in scope.
`ifndef WIRELESS_BUZZER_LOCKOUT_NODE_MACROS_SVH
`define WIRELESS_BUZZER_LOCKOUT_NODE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WBL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define WBL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/wbl_pkg.sv
package wbl_pkg;

	// Packet format
	localparam logic [7:0] CMD_ANNOUNCE = 8'h41;
	localparam logic [7:0] CMD_CLAIM    = 8'h43;
	localparam logic [7:0] PKT_LEN      = 8'd7;

	// Timing constants (ms)
	localparam logic [31:0] GUARD_MS      = 32'd250;
	localparam logic [7:0]  BACKOFF_MIN   = 8'd20;
	localparam logic [15:0] LOCKOUT_RESET = 16'd2000;

	// Node state codes as seen on node_state
	localparam logic [1:0] NODE_READY  = 2'd0;
	localparam logic [1:0] NODE_ARMING = 2'd1;
	localparam logic [1:0] NODE_ACTIVE = 2'd2;
	localparam logic [1:0] NODE_LOCKED = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_IS_MASTER  = 2'd0;
	localparam logic [1:0] CFG_LOCK_LEN   = 2'd1;
	localparam logic [1:0] CFG_OWN_SERIAL = 2'd2;

	typedef struct packed {
		logic        is_master;
		logic [15:0] lock_len;
		logic [31:0] own_serial;
	} cfg_t;

	// Contents of the input register, with the state-independent sums done
	typedef struct packed {
		logic [31:0] now_ms;
		logic        button;
		logic        free_tx;
		logic        lock;       // well-formed packet with the expected command
		logic        own_src;    // packet source is this node
		logic [31:0] rx_source;
		logic [15:0] rx_time_left;
		logic [31:0] next_at;    // now + backoff, before the guard check
		logic [31:0] unlock_rx;  // now + received time
		logic [31:0] unlock_btn; // now + local lock length
	} item_t;

	// Random byte mod 60 (master) or mod 120 (slave), by compare and subtract
	function automatic logic [6:0] backoff_mod(input logic [7:0] rnd, input logic master);
		logic [7:0] r;
		begin
			if (master) begin
				priority if (rnd >= 8'd240) r = rnd - 8'd240;
				else if (rnd >= 8'd180) r = rnd - 8'd180;
				else if (rnd >= 8'd120) r = rnd - 8'd120;
				else if (rnd >= 8'd60)  r = rnd - 8'd60;
				else                    r = rnd;
			end else begin
				priority if (rnd >= 8'd240) r = rnd - 8'd240;
				else if (rnd >= 8'd120) r = rnd - 8'd120;
				else                    r = rnd;
			end
			backoff_mod = r[6:0];
		end
	endfunction

endpackage

>>> src/wbl_intake.sv
module wbl_intake import wbl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] now_ms,
	input  logic        button_pressed,
	input  logic [7:0]  random_value,
	input  logic        tx_free,
	input  logic        rx_valid,
	input  logic [7:0]  rx_length,
	input  logic [7:0]  rx_command,
	input  logic [31:0] rx_source,
	input  logic [15:0] rx_time_left,
	input  logic        hold,
	output logic        item_valid,
	output item_t       item
);

	logic        valid_s1;
	item_t       item_s1;
	item_t       item_d;
	logic [7:0]  backoff;
	logic [7:0]  want_cmd;

	// Input register stays full while the result register is blocked
	assign in_stall = valid_s1 & hold;

	// State-independent precompute
	always_comb begin
		want_cmd = cfg.is_master ? CMD_CLAIM : CMD_ANNOUNCE;
		backoff  = {1'b0, backoff_mod(random_value, cfg.is_master)} + BACKOFF_MIN;
		item_d.now_ms       = now_ms;
		item_d.button       = button_pressed;
		item_d.free_tx      = tx_free;
		item_d.lock         = rx_valid & (rx_length == PKT_LEN) & (rx_command == want_cmd);
		item_d.own_src      = (rx_source == cfg.own_serial);
		item_d.rx_source    = rx_source;
		item_d.rx_time_left = rx_time_left;
		item_d.next_at      = now_ms + {24'd0, backoff};
		item_d.unlock_rx    = now_ms + {16'd0, rx_time_left};
		item_d.unlock_btn   = now_ms + {16'd0, cfg.lock_len};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= item_d;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

>>> src/wbl_fsm.sv
module wbl_fsm import wbl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        item_valid,
	input  item_t       item,
	output logic        hold,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  node_state,
	output logic        send_valid,
	output logic        send_announce,
	output logic [31:0] send_id,
	output logic [15:0] send_time_left
);

	typedef enum logic [1:0] {
		MODE_READY  = NODE_READY,
		MODE_ARMING = NODE_ARMING,
		MODE_ACTIVE = NODE_ACTIVE,
		MODE_LOCKED = NODE_LOCKED
	} mode_t;

	mode_t       mode_q, mode_n;
	logic [31:0] unlock_q, unlock_n;
	logic [31:0] resend_q, resend_n;
	logic [31:0] winner_q, winner_n;
	logic        was_down_q;
	logic        out_valid_q;
	logic [1:0]  state_q;
	logic        snd_q, snd_n;
	logic        ann_q, ann_n;
	logic [31:0] id_q, id_n;
	logic [15:0] tl_q, tl_n;

	logic        advance;
	logic        rdy_lock;
	logic        rdy_press;
	logic [31:0] unlock_sel;
	logic [31:0] guard_at;
	logic [31:0] next_res;
	logic [31:0] remaining;
	logic        timed_out;
	logic        resend_due;

	assign hold    = out_valid_q & out_stall;
	assign advance = item_valid & ~hold;

	// Shared terms; the guard uses the unlock time this tick is setting
	always_comb begin
		rdy_lock   = item.lock & ~item.own_src;
		rdy_press  = item.button & ~was_down_q;
		priority if (mode_q == MODE_READY && rdy_lock)  unlock_sel = item.unlock_rx;
		else if (mode_q == MODE_READY && rdy_press)     unlock_sel = item.unlock_btn;
		else                                            unlock_sel = unlock_q;
		guard_at   = unlock_sel - GUARD_MS;
		next_res   = (item.next_at > guard_at) ? 32'hFFFF_FFFF : item.next_at;
		remaining  = unlock_q - item.now_ms;
		timed_out  = item.now_ms > unlock_q;
		resend_due = item.now_ms > resend_q;
	end

	// Next state and packet
	always_comb begin
		mode_n   = mode_q;
		unlock_n = unlock_q;
		resend_n = resend_q;
		winner_n = winner_q;
		snd_n    = 1'b0;
		ann_n    = 1'b0;
		id_n     = 32'd0;
		tl_n     = 16'd0;
		unique case (mode_q)
			MODE_READY: begin
				if (rdy_lock) begin
					unlock_n = item.unlock_rx;
					mode_n   = MODE_LOCKED;
					if (cfg.is_master) begin
						winner_n = item.rx_source;
						if (item.free_tx) begin
							snd_n    = 1'b1;
							ann_n    = 1'b1;
							id_n     = item.rx_source;
							tl_n     = item.rx_time_left;
							resend_n = next_res;
						end else begin
							resend_n = item.now_ms;
						end
					end
				end else if (rdy_press) begin
					unlock_n = item.unlock_btn;
					if (cfg.is_master) begin
						mode_n   = MODE_ACTIVE;
						winner_n = cfg.own_serial;
					end else begin
						mode_n = MODE_ARMING;
					end
					if (item.free_tx) begin
						snd_n    = 1'b1;
						ann_n    = cfg.is_master;
						id_n     = cfg.own_serial;
						tl_n     = cfg.lock_len;
						resend_n = next_res;
					end else begin
						resend_n = item.now_ms;
					end
				end
			end
			MODE_ARMING: begin
				if (timed_out) begin
					mode_n = MODE_READY;
				end else if (item.lock) begin
					if (item.own_src) begin
						mode_n = MODE_ACTIVE;
					end else begin
						mode_n   = MODE_LOCKED;
						unlock_n = item.unlock_rx;
					end
				end else if (resend_due) begin
					// claim resend moves on even when the transmitter is busy
					if (item.free_tx) begin
						snd_n = 1'b1;
						id_n  = cfg.own_serial;
						tl_n  = remaining[15:0];
					end
					resend_n = next_res;
				end
			end
			MODE_ACTIVE, MODE_LOCKED: begin
				if (timed_out) begin
					mode_n = MODE_READY;
				end else if (cfg.is_master && resend_due) begin
					if (item.free_tx) begin
						snd_n    = 1'b1;
						ann_n    = 1'b1;
						id_n     = winner_q;
						tl_n     = remaining[15:0];
						resend_n = next_res;
					end else begin
						resend_n = item.now_ms;
					end
				end
			end
			default: mode_n = MODE_READY;
		endcase
	end

	// Node state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_READY;
			unlock_q    <= 32'd0;
			resend_q    <= 32'd0;
			winner_q    <= 32'd0;
			was_down_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				mode_q     <= mode_n;
				unlock_q   <= unlock_n;
				resend_q   <= resend_n;
				winner_q   <= winner_n;
				was_down_q <= item.button;
			end
			if (!hold) begin
				out_valid_q <= item_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			state_q <= mode_n;
			snd_q   <= snd_n;
			ann_q   <= ann_n;
			id_q    <= id_n;
			tl_q    <= tl_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign node_state     = state_q;
	assign send_valid     = snd_q;
	assign send_announce  = ann_q;
	assign send_id        = id_q;
	assign send_time_left = tl_q;

endmodule

>>> src/wireless_buzzer_lockout_node.sv
// Quiz-buzzer lockout node. Each input transaction is one service tick (time, button level,
// random byte, transmitter-free flag, optional received packet); each tick yields exactly one
// result transaction with the new node state and an optional claim or announce packet. A tick
// is accepted every clock cycle while in_stall is low; it goes into the input register, then takes
// one pass through the state logic into the result register, which drives the outputs. Throughput
// is set by that single state-update pass, which reads the state the previous tick left.
// Configuration writes take effect on the next cycle and should only be made while no tick is in
// flight.
`include "wireless_buzzer_lockout_node_macros.svh"

module wireless_buzzer_lockout_node import wbl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	// tick input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] now_ms,
	input  logic        button_pressed,
	input  logic [7:0]  random_value,
	input  logic        tx_free,
	input  logic        rx_valid,
	input  logic [7:0]  rx_length,
	input  logic [7:0]  rx_command,
	input  logic [31:0] rx_source,
	input  logic [15:0] rx_time_left,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  node_state,
	output logic        send_valid,
	output logic        send_announce,
	output logic [31:0] send_id,
	output logic [15:0] send_time_left
);

	cfg_t  cfg_q;
	logic  hold;
	logic  item_valid;
	item_t item;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.is_master  <= 1'b0;
			cfg_q.lock_len   <= LOCKOUT_RESET;
			cfg_q.own_serial <= 32'd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_IS_MASTER:  cfg_q.is_master  <= cfg_wdata[0];
				CFG_LOCK_LEN:   cfg_q.lock_len   <= cfg_wdata[15:0];
				CFG_OWN_SERIAL: cfg_q.own_serial <= cfg_wdata;
				default: ;
			endcase
		end
	end

	wbl_intake u_intake (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.now_ms         (now_ms),
		.button_pressed (button_pressed),
		.random_value   (random_value),
		.tx_free        (tx_free),
		.rx_valid       (rx_valid),
		.rx_length      (rx_length),
		.rx_command     (rx_command),
		.rx_source      (rx_source),
		.rx_time_left   (rx_time_left),
		.hold           (hold),
		.item_valid     (item_valid),
		.item           (item)
	);

	wbl_fsm u_fsm (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.item_valid     (item_valid),
		.item           (item),
		.hold           (hold),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.node_state     (node_state),
		.send_valid     (send_valid),
		.send_announce  (send_announce),
		.send_id        (send_id),
		.send_time_left (send_time_left)
	);

	// Checks
	`WBL_ASSERT_NOW(a_stall_only_when_full, in_stall, item_valid && out_valid && out_stall, "input stalled while pipeline can move")
	`WBL_ASSERT_NEXT(a_result_has_source, !out_valid && !item_valid, !out_valid, "result without a tick")
	`WBL_ASSERT_NOW(a_ready_sends_nothing, out_valid && node_state == NODE_READY, !send_valid, "packet sent while ready")
	`WBL_ASSERT_NOW(a_arming_claims_only, out_valid && node_state == NODE_ARMING && send_valid, !send_announce, "announce sent while arming")

endmodule
